### hdl/rahc_pkg.sv
// Package with the constants and types shared by the row alpha hint classifier files.
`default_nettype none

package rahc_pkg;

  localparam int TILE_ROWS = 64;
  localparam int ROW_W     = 6;
  localparam int ALPHA_W   = 8;
  localparam int HINT_W    = 2;
  localparam int OP_W      = 2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR = 8'd0;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [HINT_W-1:0] {
    HINT_UNKNOWN     = 2'd0,
    HINT_OPAQUE      = 2'd1,
    HINT_TRANSPARENT = 2'd2,
    HINT_MIXED       = 2'd3
  } hint_t;

endpackage

`default_nettype wire

### hdl/row_alpha_hint_classifier.sv
// Row alpha hint classifier: per-row hint store with pixel classification.
// A result word passes the s1 register and then the output register to the master side.
// Throughput: one word per cycle; a stalled master side backs up the slave side.
// The hint store read is registered at acceptance, with forwarding of a same-cycle write.
// Reset: synchronous; all hints become unknown at once through per-row valid bits,
// the open classification run is closed and has_alpha returns to 1.
`default_nettype none

module row_alpha_hint_classifier
  import rahc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_wdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0: row[5:0], alpha[13:6], hint_value[15:14].
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: op[1:0].
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // Fields from bit 0: out_row[5:0], hint[7:6].
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  logic has_alpha;

  logic [HINT_W-1:0] mem [TILE_ROWS];
  logic [TILE_ROWS-1:0] vbit;

  logic               s1_v;
  op_t                s1_op;
  logic [ROW_W-1:0]   s1_row;
  logic [ALPHA_W-1:0] s1_alpha;
  logic               s1_last;
  hint_t              s1_hv;
  logic [HINT_W-1:0]  s1_mem;
  logic               s1_vbit;
  logic               fwd_hit;
  hint_t              fwd_hint;

  logic [ALPHA_W-1:0] first_alpha;
  logic               row_is_mixed;
  logic               row_in_progress;

  logic [ALPHA_W-1:0] first_alpha_next;
  logic               row_is_mixed_next;
  logic               row_in_progress_next;

  logic               o_v;
  logic [ROW_W-1:0]   o_row;
  hint_t              o_hint;

  logic               accept;
  logic               s1_adv;
  logic               o_ready;
  logic               in_range;
  logic               s1_in_range;
  hint_t              h_rd;
  hint_t              res_hint;
  logic               res_v;
  logic               we;
  hint_t              wr_hint;
  logic               mixed_now;

  logic [ROW_W-1:0]   s_row;
  assign s_row = s_axis_tdata[ROW_W-1:0];

  assign in_range    = ({1'b0, s_row} < (ROW_W+1)'(TILE_ROWS));
  assign s1_in_range = ({1'b0, s1_row} < (ROW_W+1)'(TILE_ROWS));

  assign o_ready       = !o_v || m_axis_tready;
  assign s1_adv        = s1_v && (!res_v || o_ready);
  assign s_axis_tready = !s1_v || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (!s1_in_range) begin
      h_rd = HINT_UNKNOWN;
    end else if (fwd_hit) begin
      h_rd = fwd_hint;
    end else if (s1_vbit) begin
      h_rd = hint_t'(s1_mem);
    end else begin
      h_rd = HINT_UNKNOWN;
    end
  end

  always_comb begin
    res_v                = 1'b0;
    res_hint             = h_rd;
    we                   = 1'b0;
    wr_hint              = s1_hv;
    first_alpha_next     = first_alpha;
    row_is_mixed_next    = row_is_mixed;
    row_in_progress_next = row_in_progress;
    mixed_now            = row_is_mixed;
    case (s1_op)
      OP_READ: begin
        res_v = 1'b1;
      end
      OP_WRITE: begin
        we = s1_in_range;
      end
      OP_PIXEL: begin
        if (!has_alpha) begin
          if (s1_last) begin
            res_v                = 1'b1;
            res_hint             = HINT_OPAQUE;
            we                   = s1_in_range;
            wr_hint              = HINT_OPAQUE;
            row_in_progress_next = 1'b0;
          end
        end else if (h_rd == HINT_UNKNOWN) begin
          if (!row_in_progress) begin
            first_alpha_next = s1_alpha;
            mixed_now        = (s1_alpha != ALPHA_CLEAR) && (s1_alpha != ALPHA_FULL);
          end else if (s1_alpha != first_alpha) begin
            mixed_now = 1'b1;
          end
          row_is_mixed_next    = mixed_now;
          row_in_progress_next = 1'b1;
          if (s1_last) begin
            if (mixed_now) begin
              res_hint = HINT_MIXED;
            end else if (first_alpha_next == ALPHA_CLEAR) begin
              res_hint = HINT_TRANSPARENT;
            end else begin
              res_hint = HINT_OPAQUE;
            end
            res_v                = 1'b1;
            we                   = s1_in_range;
            wr_hint              = res_hint;
            row_in_progress_next = 1'b0;
          end
        end else if (s1_last) begin
          res_v                = 1'b1;
          row_in_progress_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_alpha <= 1'b1;
    end else if (cfg_we) begin
      has_alpha <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && we) begin
      mem[s1_row] <= wr_hint;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      s1_mem <= mem[s_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
    end else if (s1_adv && we) begin
      vbit[s1_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (accept) begin
      s1_v    <= 1'b1;
      fwd_hit <= s1_adv && we && (s1_row == s_row);
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= op_t'(s_axis_tuser);
      s1_row   <= s_row;
      s1_alpha <= s_axis_tdata[ROW_W+ALPHA_W-1:ROW_W];
      s1_hv    <= hint_t'(s_axis_tdata[ROW_W+ALPHA_W+HINT_W-1:ROW_W+ALPHA_W]);
      s1_last  <= s_axis_tlast;
      s1_vbit  <= in_range ? vbit[s_row] : 1'b0;
      fwd_hint <= wr_hint;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_alpha     <= '0;
      row_is_mixed    <= 1'b0;
      row_in_progress <= 1'b0;
    end else if (s1_adv) begin
      first_alpha     <= first_alpha_next;
      row_is_mixed    <= row_is_mixed_next;
      row_in_progress <= row_in_progress_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (s1_adv && res_v) begin
      o_v <= 1'b1;
    end else if (m_axis_tready) begin
      o_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_v) begin
      o_row  <= s1_row;
      o_hint <= res_hint;
    end
  end

  assign m_axis_tvalid = o_v;
  assign m_axis_tdata  = {o_hint, o_row};

endmodule

`default_nettype wire

### hdl/rahc_checker.sv
// Port-level checker for the row alpha hint classifier and its bind statement.
`default_nettype none

module rahc_checker
  import rahc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A result word that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed or dropped while stalled");

  // The slave side only backs up when a result word is waiting on a stalled master side.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("slave side stalled without a blocked result word");

  // After reset the block is empty and ready.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("not ready after reset");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word shown after reset");

endmodule

bind row_alpha_hint_classifier rahc_checker u_rahc_checker (.*);

`default_nettype wire
